[hdl/gpd_pkg.sv]
// ============================================================================
// gpd_pkg
// Shared types, constants and the arctangent table for the geo point
// distance pipeline.
// ============================================================================
package gpd_pkg;

   // datapath widths
   localparam int XY_W        = 33;
   localparam int Z_W         = 34;
   localparam int SQ_W        = 63;
   localparam int SQRT_STEPS  = (SQ_W + 1) / 2;

   // angle units are 1e-7 degree
   localparam logic signed [33:0] DEG_180   = 34'sd1800000000;
   localparam logic signed [33:0] DEG_360   = 34'sd3600000000;
   localparam logic signed [33:0] DEG_90    = 34'sd900000000;
   localparam logic signed [30:0] LAT_LIMIT = 31'sd800000000;

   // fixed-point constants (Q30 radians, Q60 scale for degree conversion)
   localparam logic [30:0]          RAD_PER_UNIT_Q60 = 31'd2012227627;
   localparam logic [29:0]          RADIUS_CM        = 30'd637099681;
   localparam logic signed [XY_W-1:0] GAIN_Q30       = 33'sd652032874;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30    = 34'sd1686629713;
   localparam logic signed [31:0]   ONE_Q30          = 32'sd1073741824;
   localparam logic [30:0]          OUT_MAX          = 31'h7FFF_FFFF;

   // one CORDIC vector as it moves from cell to cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_vec_type;

   // square root working pair: remainder and partial root
   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_vec_type;

   // side data riding along the chains
   typedef struct packed {
      logic        neg;
      logic [32:0] ux;
      logic [32:0] uy;
   } rot_side_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] c;
   } sqrt_side_type;

   // arctangent of 2^-step in Q30
   function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned step);
      logic signed [Z_W-1:0] val;
      unique case (step)
         0: val = 34'sd843314857;
         1: val = 34'sd497837829;
         2: val = 34'sd263043837;
         3: val = 34'sd133525159;
         4: val = 34'sd67021687;
         5: val = 34'sd33543516;
         6: val = 34'sd16775851;
         7: val = 34'sd8388437;
         8: val = 34'sd4194283;
         9: val = 34'sd2097149;
         default: val = (step <= 30) ? (Z_W'(1) << (30 - step)) : '0;
      endcase
      return val;
   endfunction

endpackage

[hdl/geo_point_distance_unit.sv]
// ============================================================================
// geo_point_distance_unit
// Distance between two points on a sphere, great circle or flat
// approximation, as one pipeline of CORDIC and root cells.
// ============================================================================
// Usage:
//   req_* carries one point pair per transaction (longitude/latitude in
//   1e-7 degree). rsp_distance_cm returns the distance in centimeters,
//   one result per request, in request order.
//   csr_write_data is written to the mode register (0 great circle,
//   1 flat) when csr_write_enable is high; write it only while the
//   pipeline is empty.
// Depth: set by the two CORDIC chains, one cell per step, and the
//   32-cell square root chain.
// Throughput: one transaction per cycle while not stalled; every stage
//   advances together.
// Stall: when a result sits in the output register and rsp_stall is high
//   the whole pipeline holds and req_stall is raised; the output keeps its
//   value until taken.
// Reset: clears the mode register and all valid bits; the block accepts
//   a request in the first cycle after reset.
// ============================================================================
module geo_point_distance_unit #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [32:0] req_lon_a,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [32:0] req_lon_b,
   input  logic signed [30:0] req_lat_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_distance_cm
);
   import gpd_pkg::*;

   localparam int PIPE_DEPTH = 44 + 2 * CORDIC_STEPS;

   // ------------------------------------------------------------------
   // control
   // ------------------------------------------------------------------
   logic                  distance_mode_ff;
   logic [PIPE_DEPTH-1:0] stage_vld_ff;
   logic                  rsp_valid_ff;
   logic [30:0]           rsp_dist_ff;
   logic                  adv;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_mode_ff <= 1'b0;
         stage_vld_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            distance_mode_ff <= csr_write_data;
         end
         if (adv) begin
            stage_vld_ff <= {stage_vld_ff[PIPE_DEPTH-2:0], req_valid};
            rsp_valid_ff <= stage_vld_ff[PIPE_DEPTH-1];
         end
      end
   end

   function automatic logic signed [31:0] wrap_lon(input logic signed [32:0] lon);
      logic signed [33:0] w;
      w = 34'(lon);
      if (w > DEG_180) begin
         w = w - DEG_360;
      end else if (w < -DEG_180) begin
         w = w + DEG_360;
      end
      if (w == -DEG_180) begin
         w = DEG_180;
      end
      return w[31:0];
   endfunction

   function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] lat);
      logic signed [30:0] r;
      if (lat > LAT_LIMIT) begin
         r = LAT_LIMIT;
      end else if (lat < -LAT_LIMIT) begin
         r = -LAT_LIMIT;
      end else begin
         r = lat;
      end
      return r;
   endfunction

   // round-half-up rescale of a Q60 product back to Q30
   function automatic logic signed [33:0] rnd_q30(input logic signed [67:0] p);
      logic signed [67:0] t;
      t = p + 68'sd536870912;
      t = t >>> 30;
      return t[33:0];
   endfunction

   // ------------------------------------------------------------------
   // S1: wrap longitudes, clamp latitudes
   // ------------------------------------------------------------------
   logic signed [31:0] la1_ff, lb1_ff;
   logic signed [30:0] pa1_ff, pb1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         la1_ff <= wrap_lon(req_lon_a);
         lb1_ff <= wrap_lon(req_lon_b);
         pa1_ff <= clamp_lat(req_lat_a);
         pb1_ff <= clamp_lat(req_lat_b);
      end
   end

   // ------------------------------------------------------------------
   // S2: angle sources per mode, split to sign and magnitude
   // ------------------------------------------------------------------
   logic signed [33:0] dl, rx, ry, mean;
   logic signed [33:0] src [3];
   logic               d_neg;
   logic               sgn2_in [3];
   logic [31:0]        mag2_in [3];
   logic               sgn2_ff [3];
   logic [31:0]        mag2_ff [3];
   logic               neg2_ff;

   always_comb begin
      dl    = 34'(lb1_ff) - 34'(la1_ff);
      d_neg = 1'b0;
      if (dl > DEG_180) begin
         dl = dl - DEG_360;
      end
      if (dl < -DEG_180) begin
         dl = dl + DEG_360;
      end
      if (dl < 0) begin
         dl = -dl;
      end
      if (dl > DEG_90) begin
         dl    = DEG_180 - dl;
         d_neg = 1'b1;
      end
      rx   = 34'(la1_ff) - 34'(lb1_ff);
      ry   = 34'(pa1_ff) - 34'(pb1_ff);
      mean = 34'(pa1_ff) + 34'(pb1_ff);
      src[0] = distance_mode_ff ? rx   : 34'(pa1_ff);
      src[1] = distance_mode_ff ? ry   : 34'(pb1_ff);
      src[2] = distance_mode_ff ? mean : dl;
      for (int k = 0; k < 3; k++) begin
         sgn2_in[k] = src[k][33];
         mag2_in[k] = src[k][33] ? 32'(-src[k]) : src[k][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sgn2_ff <= sgn2_in;
         mag2_ff <= mag2_in;
         neg2_ff <= d_neg;
      end
   end

   // ------------------------------------------------------------------
   // S3: degree-to-radian partial products
   // ------------------------------------------------------------------
   logic [46:0] pl3_ff [3];
   logic [46:0] ph3_ff [3];
   logic        sgn3_ff [3];
   logic        neg3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            pl3_ff[k] <= 47'(mag2_ff[k][15:0]) * 47'(RAD_PER_UNIT_Q60);
            ph3_ff[k] <= 47'(mag2_ff[k][31:16]) * 47'(RAD_PER_UNIT_Q60);
         end
         sgn3_ff <= sgn2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // ------------------------------------------------------------------
   // S4: sum, round and restore sign; mean latitude uses a half scale
   // ------------------------------------------------------------------
   logic [63:0]           sum4 [3];
   logic [32:0]           r4 [3];
   logic signed [Z_W-1:0] z4_in [3];
   logic signed [Z_W-1:0] z4_ff [3];
   logic                  half4;
   rot_side_type          side4_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         half4   = (k == 2) && distance_mode_ff;
         sum4[k] = 64'({ph3_ff[k], 16'h0000}) + 64'(pl3_ff[k])
                 + (half4 ? 64'h4000_0000 : 64'h2000_0000);
         r4[k]   = half4 ? 33'(sum4[k] >> 31) : 33'(sum4[k] >> 30);
         z4_in[k] = sgn3_ff[k] ? -Z_W'(r4[k]) : Z_W'(r4[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z4_ff       <= z4_in;
         side4_ff.neg <= neg3_ff;
         side4_ff.ux  <= r4[0];
         side4_ff.uy  <= r4[1];
      end
   end

   // ------------------------------------------------------------------
   // rotation chains: cos/sin of the three angles
   // ------------------------------------------------------------------
   cordic_vec_type rot_vec [3][CORDIC_STEPS+1];
   rot_side_type   rot_side_ff [CORDIC_STEPS];

   for (genvar ch = 0; ch < 3; ch++) begin : g_rot
      assign rot_vec[ch][0] = '{x: GAIN_Q30, y: '0, z: z4_ff[ch]};
      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
         gpd_cordic_cell #(
            .STEP      (k),
            .VECTORING (1'b0)
         ) u_rot_cell (
            .clock     (clock),
            .en        (adv),
            .cell_din  (rot_vec[ch][k]),
            .cell_dout (rot_vec[ch][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_side_ff[0] <= side4_ff;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            rot_side_ff[k] <= rot_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // P1: first products (cosine law) and radius scaling (flat)
   // ------------------------------------------------------------------
   logic signed [XY_W-1:0] c1, s1, c2, s2, cd, cb;
   logic [30:0]            cbc;
   rot_side_type           rside;
   logic signed [67:0]     prod_a5_ff, prod_b5_ff;
   logic signed [XY_W-1:0] cdn5_ff;
   logic [30:0]            cbc5_ff;
   logic [46:0]            pxl5_ff, pxh5_ff, pyl5_ff, pyh5_ff;

   always_comb begin
      c1    = rot_vec[0][CORDIC_STEPS].x;
      s1    = rot_vec[0][CORDIC_STEPS].y;
      c2    = rot_vec[1][CORDIC_STEPS].x;
      s2    = rot_vec[1][CORDIC_STEPS].y;
      cd    = rot_vec[2][CORDIC_STEPS].x;
      cb    = rot_vec[2][CORDIC_STEPS].x;
      rside = rot_side_ff[CORDIC_STEPS-1];
      if (cb[XY_W-1]) begin
         cbc = '0;
      end else if (cb > XY_W'(ONE_Q30)) begin
         cbc = 31'(ONE_Q30);
      end else begin
         cbc = cb[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_a5_ff <= 68'(s1) * 68'(s2);
         prod_b5_ff <= 68'(c1) * 68'(c2);
         cdn5_ff    <= rside.neg ? -cd : cd;
         cbc5_ff    <= cbc;
         pxl5_ff    <= 47'(rside.ux[16:0]) * 47'(RADIUS_CM);
         pxh5_ff    <= 47'(rside.ux[32:17]) * 47'(RADIUS_CM);
         pyl5_ff    <= 47'(rside.uy[16:0]) * 47'(RADIUS_CM);
         pyh5_ff    <= 47'(rside.uy[32:17]) * 47'(RADIUS_CM);
      end
   end

   // ------------------------------------------------------------------
   // P2: rescale products; finish the radius scaling
   // ------------------------------------------------------------------
   logic signed [33:0]     m1_6_ff, m2_6_ff;
   logic signed [XY_W-1:0] cdn6_ff;
   logic [30:0]            cbc6_ff;
   logic [31:0]            lx0_6_ff, ly6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_6_ff  <= rnd_q30(prod_a5_ff);
         m2_6_ff  <= rnd_q30(prod_b5_ff);
         cdn6_ff  <= cdn5_ff;
         cbc6_ff  <= cbc5_ff;
         lx0_6_ff <= 32'((64'({pxh5_ff, 17'h00000}) + 64'(pxl5_ff) + 64'h2000_0000) >> 30);
         ly6_ff   <= 32'((64'({pyh5_ff, 17'h00000}) + 64'(pyl5_ff) + 64'h2000_0000) >> 30);
      end
   end

   // ------------------------------------------------------------------
   // P3: cos(lat1)cos(lat2)cos(dlon); flat x times cos(mean latitude)
   // ------------------------------------------------------------------
   logic signed [67:0] prod_c7_ff;
   logic signed [33:0] m1_7_ff;
   logic [62:0]        prodx7_ff;
   logic [31:0]        ly7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_c7_ff <= 68'(m2_6_ff) * 68'(cdn6_ff);
         m1_7_ff    <= m1_6_ff;
         prodx7_ff  <= 63'(lx0_6_ff) * 63'(cbc6_ff);
         ly7_ff     <= ly6_ff;
      end
   end

   // ------------------------------------------------------------------
   // P4: cosine of the central angle, clamped; flat legs and overflow
   // ------------------------------------------------------------------
   logic signed [35:0] csum;
   logic signed [31:0] c8_in;
   logic [32:0]        lx8;
   logic signed [31:0] c8_ff;
   logic [30:0]        lx8_ff, ly8_ff;
   logic               sat8_ff;

   always_comb begin
      csum = 36'(m1_7_ff) + 36'(rnd_q30(prod_c7_ff));
      if (csum > 36'(ONE_Q30)) begin
         c8_in = ONE_Q30;
      end else if (csum < -36'(ONE_Q30)) begin
         c8_in = -ONE_Q30;
      end else begin
         c8_in = csum[31:0];
      end
      lx8 = 33'((prodx7_ff + 63'h2000_0000) >> 30);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c8_ff   <= c8_in;
         lx8_ff  <= lx8[30:0];
         ly8_ff  <= ly7_ff[30:0];
         sat8_ff <= (lx8 > 33'(OUT_MAX)) || (ly7_ff > 32'(OUT_MAX));
      end
   end

   // ------------------------------------------------------------------
   // P5: squares
   // ------------------------------------------------------------------
   logic [60:0]        csq9_ff;
   logic [61:0]        lx2_9_ff, ly2_9_ff;
   logic signed [31:0] c9_ff;
   logic               sat9_ff;
   logic signed [63:0] csq9_in;

   assign csq9_in = 64'(c8_ff) * 64'(c8_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         csq9_ff  <= csq9_in[60:0];
         lx2_9_ff <= 62'(lx8_ff) * 62'(lx8_ff);
         ly2_9_ff <= 62'(ly8_ff) * 62'(ly8_ff);
         c9_ff    <= c8_ff;
         sat9_ff  <= sat8_ff;
      end
   end

   // ------------------------------------------------------------------
   // P6: square root operand
   // ------------------------------------------------------------------
   sqrt_vec_type  sq_init_ff;
   sqrt_side_type sq_side10_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_init_ff.rem  <= distance_mode_ff ? (63'(lx2_9_ff) + 63'(ly2_9_ff))
                                             : ((63'(1) << 60) - 63'(csq9_ff));
         sq_init_ff.root <= '0;
         sq_side10_ff.sat <= sat9_ff;
         sq_side10_ff.c   <= c9_ff;
      end
   end

   // ------------------------------------------------------------------
   // square root chain, one root bit per cell
   // ------------------------------------------------------------------
   sqrt_vec_type  sq_vec [SQRT_STEPS+1];
   sqrt_side_type sq_side_ff [SQRT_STEPS];

   assign sq_vec[0] = sq_init_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      gpd_sqrt_cell #(
         .STEP (k)
      ) u_sqrt_cell (
         .clock     (clock),
         .en        (adv),
         .cell_din  (sq_vec[k]),
         .cell_dout (sq_vec[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= sq_side10_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // V0: flat result rounding; quarter-turn prerotation for atan2
   // ------------------------------------------------------------------
   logic [31:0]        root_q;
   logic [32:0]        rr;
   logic [30:0]        flat_in;
   sqrt_side_type      qside;
   cordic_vec_type     pre_in;
   cordic_vec_type     pre_vec_ff;
   logic [30:0]        flat_pre_ff;

   always_comb begin
      qside  = sq_side_ff[SQRT_STEPS-1];
      root_q = sq_vec[SQRT_STEPS].root[31:0];
      rr     = 33'(root_q) + ((sq_vec[SQRT_STEPS].rem > sq_vec[SQRT_STEPS].root) ? 33'd1
                                                                               : 33'd0);
      if (qside.sat || (rr > 33'(OUT_MAX))) begin
         flat_in = OUT_MAX;
      end else begin
         flat_in = rr[30:0];
      end
      if (qside.c[31]) begin
         pre_in.x = XY_W'(root_q);
         pre_in.y = -XY_W'(qside.c);
         pre_in.z = HALF_PI_Q30;
      end else begin
         pre_in.x = XY_W'(qside.c);
         pre_in.y = XY_W'(root_q);
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_vec_ff  <= pre_in;
         flat_pre_ff <= flat_in;
      end
   end

   // ------------------------------------------------------------------
   // vectoring chain: central angle = atan2(s, c)
   // ------------------------------------------------------------------
   cordic_vec_type vec_chain [CORDIC_STEPS+1];
   logic [30:0]    vec_side_ff [CORDIC_STEPS];

   assign vec_chain[0] = pre_vec_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      gpd_cordic_cell #(
         .STEP      (k),
         .VECTORING (1'b1)
      ) u_vec_cell (
         .clock     (clock),
         .en        (adv),
         .cell_din  (vec_chain[k]),
         .cell_dout (vec_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_side_ff[0] <= flat_pre_ff;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            vec_side_ff[k] <= vec_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // A1: arc length product; negative angles count as zero
   // ------------------------------------------------------------------
   logic signed [Z_W-1:0] ang;
   logic [62:0]           arc_prod_ff;
   logic [30:0]           flat_a1_ff;

   assign ang = vec_chain[CORDIC_STEPS].z;

   always_ff @(posedge clock) begin
      if (adv) begin
         arc_prod_ff <= ang[Z_W-1] ? '0 : 63'(ang[32:0]) * 63'(RADIUS_CM);
         flat_a1_ff  <= vec_side_ff[CORDIC_STEPS-1];
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic [32:0] arc_cm;
   logic [30:0] arc_sat;

   always_comb begin
      arc_cm  = 33'((arc_prod_ff + 63'h2000_0000) >> 30);
      arc_sat = (arc_cm > 33'(OUT_MAX)) ? OUT_MAX : arc_cm[30:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_dist_ff <= distance_mode_ff ? flat_a1_ff : arc_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_dist_ff;

endmodule

[hdl/gpd_cordic_cell.sv]
// ============================================================================
// gpd_cordic_cell
// One micro-rotation of a CORDIC chain, rotation or vectoring mode,
// registered and handed to the next cell.
// ============================================================================
module gpd_cordic_cell #(
   parameter int STEP      = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic                    clock,
   input  logic                    en,
   input  gpd_pkg::cordic_vec_type cell_din,
   output gpd_pkg::cordic_vec_type cell_dout
);
   import gpd_pkg::*;

   localparam logic signed [Z_W-1:0] ANGLE = atan_q30(STEP);

   cordic_vec_type         vec_ff;
   cordic_vec_type         vec_in;
   logic signed [XY_W-1:0] x_cur;
   logic signed [XY_W-1:0] y_cur;
   logic signed [Z_W-1:0]  z_cur;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic                   ccw;

   // pick direction and apply the shifted cross terms
   always_comb begin
      x_cur = cell_din.x;
      y_cur = cell_din.y;
      z_cur = cell_din.z;
      dx    = y_cur >>> STEP;
      dy    = x_cur >>> STEP;
      if (VECTORING) begin
         ccw = y_cur[XY_W-1] || (y_cur == '0);
      end else begin
         ccw = !z_cur[Z_W-1];
      end
      if (ccw) begin
         vec_in.x = x_cur - dx;
         vec_in.y = y_cur + dy;
         vec_in.z = z_cur - ANGLE;
      end else begin
         vec_in.x = x_cur + dx;
         vec_in.y = y_cur - dy;
         vec_in.z = z_cur + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign cell_dout = vec_ff;

endmodule

[hdl/gpd_sqrt_cell.sv]
// ============================================================================
// gpd_sqrt_cell
// One result bit of a restoring integer square root; the remainder left
// after the last cell is n - root^2.
// ============================================================================
module gpd_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  gpd_pkg::sqrt_vec_type cell_din,
   output gpd_pkg::sqrt_vec_type cell_dout
);
   import gpd_pkg::*;

   localparam int BIT_POS = SQ_W - 1 - 2 * STEP;
   localparam logic [SQ_W:0] TRIAL_BIT = (SQ_W + 1)'(1) << BIT_POS;

   sqrt_vec_type  vec_ff;
   sqrt_vec_type  vec_in;
   logic [SQ_W:0] trial;

   // try the next root bit against the remainder
   always_comb begin
      trial = {1'b0, cell_din.root} + TRIAL_BIT;
      if ({1'b0, cell_din.rem} >= trial) begin
         vec_in.rem  = SQ_W'({1'b0, cell_din.rem} - trial);
         vec_in.root = (cell_din.root >> 1) + TRIAL_BIT[SQ_W-1:0];
      end else begin
         vec_in.rem  = cell_din.rem;
         vec_in.root = cell_din.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign cell_dout = vec_ff;

endmodule

[hdl/gpd_checker.sv]
// ============================================================================
// gpd_checker
// Port-level checks for geo_point_distance_unit, attached by bind.
// ============================================================================
module gpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [30:0] rsp_distance_cm
);

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance_cm)))
      else $error("result changed or dropped while stalled");

   // input side only stalls when a finished result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   // no stale result after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output never holds back a request
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> !req_stall)
      else $error("request stalled while output empty");

endmodule

bind geo_point_distance_unit gpd_checker u_gpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_distance_cm (rsp_distance_cm)
);

[sim/testbench.sv]
// ============================================================================
// testbench
// Checks geo_point_distance_unit against a bit-exact predictor of the
// great-circle and flat-approximation distance, with random idling and
// stalls on both channels and mode changes between phases.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 120;
   localparam bit  MODE_COSINES = 1'b0;
   localparam bit  MODE_FLAT = 1'b1;

   typedef struct {
      logic signed [32:0] lon_a;
      logic signed [30:0] lat_a;
      logic signed [32:0] lon_b;
      logic signed [30:0] lat_b;
   } point_pair_type;

   // --------------------------------------------------------------------------
   // Distance predictor and store of expected distances
   // --------------------------------------------------------------------------
   class distance_scoreboard;
      localparam int     STEPS = 28;
      localparam longint UNITS_180 = 64'sd1800000000;
      localparam longint UNITS_360 = 64'sd3600000000;
      localparam longint UNITS_90 = 64'sd900000000;
      localparam longint UNITS_80 = 64'sd800000000;
      localparam longint ONE = 64'sd1073741824;
      localparam longint HALF_PI = 64'sd1686629713;
      localparam longint GAIN = 64'sd652032874;
      localparam longint unsigned RAD_SCALE = 64'd2012227627;
      localparam longint unsigned RADIUS = 64'd637099681;
      localparam longint unsigned SAT_MAX = 64'd2147483647;

      bit          flat_mode;
      logic [30:0] expected_cm[$];
      int          mismatches;

      function longint arctan_step(int i);
         longint head[10];
         head = '{843314857, 497837829, 263043837, 133525159, 67021687,
                  33543516, 16775851, 8388437, 4194283, 2097149};
         if (i < 10) return head[i];
         if (i <= 30) return longint'(1) << (30 - i);
         return 0;
      endfunction

      function longint radians(longint units, int shift);
         longint unsigned mag, r;
         mag = (units < 0) ? longint'(-units) : units;
         r = (mag * RAD_SCALE + (64'd1 << (shift - 1))) >> shift;
         return (units < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint qmul(longint a, longint b);
         return (a * b + (longint'(1) << 29)) >>> 30;
      endfunction

      function void rotate(longint theta, output longint cs, output longint sn);
         longint x, y, z, dx, dy;
         x = GAIN; y = 0; z = theta;
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan_step(i);
            end else begin
               x += dx; y -= dy; z += arctan_step(i);
            end
         end
         cs = x;
         sn = y;
      endfunction

      function longint vector_angle(longint y, longint x);
         longint z, t, dx, dy;
         z = 0;
         // quarter-turn prerotation for the left half plane
         if (x < 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += arctan_step(i);
            end else begin
               x -= dx; y += dy; z -= arctan_step(i);
            end
         end
         return z;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint wrap_lon(longint v);
         while (v > UNITS_180) v -= UNITS_360;
         while (v < -UNITS_180) v += UNITS_360;
         if (v == -UNITS_180) v = UNITS_180;
         return v;
      endfunction

      function longint clamp_lat(longint v);
         if (v > UNITS_80) return UNITS_80;
         if (v < -UNITS_80) return -UNITS_80;
         return v;
      endfunction

      function longint unsigned great_circle(longint la, longint pa, longint lb,
                                             longint pb);
         longint c1, s1, c2, s2, cd, sd, c, s, ang, d;
         bit     far_side;
         d = lb - la;
         far_side = 0;
         if (d > UNITS_180) d -= UNITS_360;
         if (d < -UNITS_180) d += UNITS_360;
         if (d < 0) d = -d;
         if (d > UNITS_90) begin
            d = UNITS_180 - d;
            far_side = 1;
         end
         rotate(radians(pa, 30), c1, s1);
         rotate(radians(pb, 30), c2, s2);
         rotate(radians(d, 30), cd, sd);
         if (far_side) cd = -cd;
         c = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
         // keep the arccos argument within [-1, 1]
         if (c > ONE) c = ONE;
         if (c < -ONE) c = -ONE;
         s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
         ang = vector_angle(s, c);
         if (ang < 0) ang = 0;
         return (longint'(ang) * RADIUS + (64'd1 << 29)) >> 30;
      endfunction

      function longint unsigned flat_approx(longint la, longint pa, longint lb,
                                            longint pb);
         longint rx, ry, cb, sb;
         longint unsigned ux, uy, lx, ly, sq, r;
         rx = radians(la - lb, 30);
         ry = radians(pa - pb, 30);
         ux = (rx < 0) ? -rx : rx;
         uy = (ry < 0) ? -ry : ry;
         rotate(radians(pa + pb, 31), cb, sb);
         if (cb < 0) cb = 0;
         if (cb > ONE) cb = ONE;
         lx = (ux * RADIUS + (64'd1 << 29)) >> 30;
         lx = (lx * longint'(cb) + (64'd1 << 29)) >> 30;
         ly = (uy * RADIUS + (64'd1 << 29)) >> 30;
         if (lx > SAT_MAX || ly > SAT_MAX) return SAT_MAX;
         sq = lx * lx + ly * ly;
         r = int_sqrt(sq);
         if (sq - r * r > r) r++;
         return r;
      endfunction

      // note an accepted request and queue its distance
      function void note_request(point_pair_type p);
         longint la, pa, lb, pb;
         longint unsigned d;
         la = wrap_lon(longint'(p.lon_a));
         pa = clamp_lat(longint'(p.lat_a));
         lb = wrap_lon(longint'(p.lon_b));
         pb = clamp_lat(longint'(p.lat_b));
         d = flat_mode ? flat_approx(la, pa, lb, pb) : great_circle(la, pa, lb, pb);
         if (d > SAT_MAX) d = SAT_MAX;
         expected_cm.push_back(d[30:0]);
      endfunction

      // compare an accepted response with the oldest expected distance
      function void check_response(logic [30:0] got);
         logic [30:0] want;
         if (expected_cm.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: distance_cm=%0d", got);
            return;
         end
         want = expected_cm.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("distance_cm mismatch: expected %0d, actual %0d", want, got);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write_enable = 0;
   logic               csr_write_data = 0;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [32:0] req_lon_a = '0;
   logic signed [30:0] req_lat_a = '0;
   logic signed [32:0] req_lon_b = '0;
   logic signed [30:0] req_lat_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [30:0]        rsp_distance_cm;

   distance_scoreboard sb = new();
   bit                 quiet = 0;
   int                 cycles = 0;
   int                 stall_left = 0;

   geo_point_distance_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_lon_a       (req_lon_a),
      .req_lat_a       (req_lat_a),
      .req_lon_b       (req_lon_b),
      .req_lat_b       (req_lat_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance_cm (rsp_distance_cm)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: check transactions, random stall runs
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_distance_cm);
            stall_left = quiet ? 0 : $urandom_range(0, 19);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // present one request and hold it until accepted, then idle for a random gap unless quiet
   task automatic send_pair(point_pair_type p);
      int gap;
      req_valid <= 1;
      req_lon_a <= p.lon_a;
      req_lat_a <= p.lat_a;
      req_lon_b <= p.lon_b;
      req_lat_b <= p.lat_b;
      do @(posedge clock); while (req_stall);
      sb.note_request(p);
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mode change once the pipeline has drained
   task automatic write_mode(bit m);
      req_valid <= 0;
      while (sb.expected_cm.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.flat_mode = m;
   endtask

   function automatic longint signed_draw(longint unsigned span);
      longint v;
      v = longint'($urandom_range(0, span));
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type p;
      longint         la, pa, lb, pb;
      la = signed_draw(3600000000);
      pa = signed_draw(900000000);
      case ($urandom_range(0, 3))
         0: begin
            // nearby point
            lb = la + signed_draw($urandom_range(0, 1) ? 1000 : 5000000);
            pb = pa + signed_draw($urandom_range(0, 1) ? 1000 : 5000000);
         end
         1: begin
            // near the antipode
            lb = la + 64'sd1800000000 + signed_draw(2000000);
            pb = -pa + signed_draw(2000000);
         end
         default: begin
            lb = signed_draw(3600000000);
            pb = signed_draw(900000000);
         end
      endcase
      if (lb > 64'sd3600000000) lb = 64'sd3600000000;
      if (lb < -64'sd3600000000) lb = -64'sd3600000000;
      if (pb > 64'sd900000000) pb = 64'sd900000000;
      if (pb < -64'sd900000000) pb = -64'sd900000000;
      p.lon_a = 33'(la);
      p.lat_a = 31'(pa);
      p.lon_b = 33'(lb);
      p.lat_b = 31'(pb);
      return p;
   endfunction

   point_pair_type directed[$];

   initial begin
      bit m;
      int waited;
      // extremes, wrap edges, clamp edges, same point, antipodes
      directed = '{
         '{0, 0, 0, 0},
         '{1000, 2000, 1000, 2000},
         '{0, 0, 1800000000, 0},
         '{-1800000000, 0, 1800000000, 0},
         '{3600000000, 900000000, -3600000000, -900000000},
         '{-3600000000, -900000000, 3600000000, 900000000},
         '{1800000000, 800000000, -1800000000, -800000000},
         '{1800000000, 0, -1799999999, 0},
         '{-1799999999, 0, 1799999999, 0},
         '{0, 800000001, 0, -800000001},
         '{900000000, 450000000, -900000000, -450000000},
         '{900000001, 0, 0, 0},
         '{0, 0, 1, 0},
         '{0, 0, 0, 1},
         '{1799999999, 799999999, -1, -799999999},
         '{2700000000, 300000000, -900000000, 300000000},
         '{-2700000000, -300000000, 900000000, 300000000},
         '{123456789, 650000000, -987654321, -123456789},
         '{3599999999, 899999999, -3599999999, -899999999},
         '{0, 800000000, 1800000000, 800000000}
      };
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed pairs in both modes, back to back first
      quiet = 1;
      foreach (directed[i]) send_pair(directed[i]);
      write_mode(MODE_FLAT);
      quiet = 0;
      foreach (directed[i]) send_pair(directed[i]);

      // random phases, alternating mode
      for (int ph = 0; ph < 4; ph++) begin
         m = (ph % 2 == 0) ? MODE_COSINES : MODE_FLAT;
         write_mode(m);
         for (int k = 0; k < 150; k++) begin
            quiet = (k % 50) < 12;
            send_pair(random_pair());
         end
      end
      quiet = 0;
      req_valid <= 0;

      // drain
      waited = 0;
      while (sb.expected_cm.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_cm.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
